/* rtl/core/gsa_pkg.sv */
// Shared constants, codes and types of the generational slot allocator.
package gsa_pkg;

   localparam int SLOTS     = 1024;
   localparam int GEN_BITS  = 16;
   localparam int ID_BITS   = $clog2(SLOTS);
   localparam int LIM_BITS  = ID_BITS + 1;

   localparam logic [LIM_BITS-1:0] LIMIT_MIN   = LIM_BITS'(2);
   localparam logic [LIM_BITS-1:0] LIMIT_MAX   = LIM_BITS'(SLOTS);
   localparam logic [LIM_BITS-1:0] LIMIT_RESET = LIM_BITS'(SLOTS);

   // Operation codes carried on req_func
   localparam logic [2:0] FUNC_ALLOC    = 3'd0;
   localparam logic [2:0] FUNC_FREE     = 3'd1;
   localparam logic [2:0] FUNC_VALIDATE = 3'd2;
   localparam logic [2:0] FUNC_MAKE     = 3'd3;
   localparam logic [2:0] FUNC_IS_LIVE  = 3'd4;

   // One entry of the slot store
   typedef struct packed {
      logic [ID_BITS-1:0]  link;
      logic [GEN_BITS-1:0] gen;
      logic                live;
   } slot_entry_type;

   // Access beat from the control logic to the slot store
   typedef struct packed {
      logic                rd_en;
      logic [ID_BITS-1:0]  rd_addr;
      logic                wr_en;
      logic [ID_BITS-1:0]  wr_addr;
      slot_entry_type      wr_data;
   } mem_access_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

endpackage

/* rtl/core/generational_slot_allocator_unit.sv */
// Generational slot allocator: top level with control, counters and output register.
// A request beat is read into the slot store's read register; its response then goes to
// the output register, later while an older response is still stalled in it.
// A new request is stalled until the slot store read and write-back of the last one are done.
// Responses wait in an output register; a new request is taken while one waits.
// Reset (synchronous, active high): empty free list, next fresh id 1, no live slots,
// slot limit 1024. The slot store is not cleared; entry data is used only once written.
module generational_slot_allocator_unit
   import gsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic [ID_BITS-1:0]  req_slot_id,
   input  logic [GEN_BITS-1:0] req_handle_generation,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [ID_BITS-1:0]  rsp_result_id,
   output logic [GEN_BITS-1:0] rsp_result_generation,
   output logic [ID_BITS-1:0]  rsp_live_total,
   // slot limit register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LIM_BITS-1:0] csr_data
);

   state_type             state_ff, state_in;
   logic [LIM_BITS-1:0]   limit_ff;
   logic [ID_BITS-1:0]    free_head_ff, free_head_in;
   logic [LIM_BITS-1:0]   next_fresh_ff, next_fresh_in;
   logic [ID_BITS-1:0]    live_count_ff, live_count_in;

   logic [2:0]            func_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [GEN_BITS-1:0]   hgen_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [GEN_BITS-1:0]   rsp_gen_ff, rsp_gen_in;

   mem_access_type        access;
   slot_entry_type        rd_data;

   logic                  req_beat;
   logic                  done;
   logic [LIM_BITS-1:0]   limit_now;
   logic                  in_range;
   logic [GEN_BITS-1:0]   gen_bumped;

   gsa_slot_mem u_slot_mem (
      .clock   (clock),
      .access  (access),
      .rd_data (rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign done      = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);

   // Slot limit clamped to the usable range
   always_comb begin
      limit_now = limit_ff;
      if (limit_ff < LIMIT_MIN) begin
         limit_now = LIMIT_MIN;
      end else if (limit_ff > LIMIT_MAX) begin
         limit_now = LIMIT_MAX;
      end
   end

   assign in_range   = (id_ff != '0) && ({1'b0, id_ff} < next_fresh_ff);
   assign gen_bumped = (rd_data.gen + GEN_BITS'(1) == '0) ? GEN_BITS'(1)
                                                          : rd_data.gen + GEN_BITS'(1);

   // Read on the request beat, modify and write back when the lookup completes
   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      next_fresh_in = next_fresh_ff;
      live_count_in = live_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_gen_in    = rsp_gen_ff;

      access.rd_en   = req_beat;
      access.rd_addr = (req_func == FUNC_ALLOC) ? free_head_ff : req_slot_id;
      access.wr_en   = 1'b0;
      access.wr_addr = id_ff;
      access.wr_data = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_id_in    = id_ff;
               rsp_gen_in   = '0;
               case (func_ff)
                  FUNC_ALLOC: begin
                     rsp_id_in = '0;
                     if (free_head_ff != '0) begin
                        // pop the free-list head
                        access.wr_en        = 1'b1;
                        access.wr_addr      = free_head_ff;
                        access.wr_data.live = 1'b1;
                        free_head_in        = rd_data.link;
                        live_count_in       = live_count_ff + ID_BITS'(1);
                        rsp_ok_in           = 1'b1;
                        rsp_id_in           = free_head_ff;
                        rsp_gen_in          = rd_data.gen;
                     end else if (next_fresh_ff < limit_now) begin
                        // bump a never-used id
                        access.wr_en        = 1'b1;
                        access.wr_addr      = next_fresh_ff[ID_BITS-1:0];
                        access.wr_data.link = '0;
                        access.wr_data.gen  = GEN_BITS'(1);
                        access.wr_data.live = 1'b1;
                        next_fresh_in       = next_fresh_ff + LIM_BITS'(1);
                        live_count_in       = live_count_ff + ID_BITS'(1);
                        rsp_ok_in           = 1'b1;
                        rsp_id_in           = next_fresh_ff[ID_BITS-1:0];
                        rsp_gen_in          = GEN_BITS'(1);
                     end
                  end
                  FUNC_FREE: begin
                     if (in_range) begin
                        rsp_gen_in = rd_data.gen;
                     end
                     if (in_range && rd_data.live) begin
                        access.wr_en        = 1'b1;
                        access.wr_data.link = free_head_ff;
                        access.wr_data.gen  = gen_bumped;
                        access.wr_data.live = 1'b0;
                        free_head_in        = id_ff;
                        live_count_in       = live_count_ff - ID_BITS'(1);
                        rsp_ok_in           = 1'b1;
                        rsp_gen_in          = gen_bumped;
                     end
                  end
                  FUNC_VALIDATE: begin
                     if (in_range) begin
                        rsp_gen_in = rd_data.gen;
                        rsp_ok_in  = rd_data.live && (rd_data.gen == hgen_ff);
                     end
                  end
                  FUNC_MAKE: begin
                     rsp_ok_in = 1'b1;
                     if (in_range) begin
                        rsp_gen_in = rd_data.gen;
                     end
                  end
                  FUNC_IS_LIVE: begin
                     if (in_range) begin
                        rsp_gen_in = rd_data.gen;
                        rsp_ok_in  = rd_data.live;
                     end
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LIMIT_RESET;
         free_head_ff  <= '0;
         next_fresh_ff <= LIM_BITS'(1);
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         next_fresh_ff <= next_fresh_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   // Captured request and response payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff <= req_func;
         id_ff   <= req_slot_id;
         hgen_ff <= req_handle_generation;
      end
      rsp_ok_ff  <= rsp_ok_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_gen_ff <= rsp_gen_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ok                = rsp_ok_ff;
   assign rsp_result_id         = rsp_id_ff;
   assign rsp_result_generation = rsp_gen_ff;
   assign rsp_live_total        = live_count_ff;

`ifndef NO_ASSERTIONS
   // live slots never outnumber the ids handed out so far
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, live_count_ff} < next_fresh_ff)
      else $error("live count exceeds handed-out ids");

   // fresh ids never pass the pool size
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      next_fresh_ff <= LIMIT_MAX)
      else $error("next fresh id beyond pool");

   // a request beat always moves into the lookup cycle
   a_beat_lookup: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_LOOKUP))
      else $error("request beat did not start a lookup");

   // a new response only comes out of a lookup
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("response raised outside a lookup");
`endif

endmodule

/* rtl/core/gsa_slot_mem.sv */
// Slot store: free-list link, generation and live mark per slot id.
module gsa_slot_mem
   import gsa_pkg::*;
(
   input  logic           clock,
   input  mem_access_type access,
   output slot_entry_type rd_data
);

   slot_entry_type slot_mem [SLOTS];
   slot_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (access.wr_en) begin
         slot_mem[access.wr_addr] <= access.wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (access.rd_en) begin
         rd_data_ff <= slot_mem[access.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/tb_generational_slot_allocator_unit.sv */
// Self-checking testbench for the generational slot allocator unit.
`timescale 1ns / 1ps

module tb_generational_slot_allocator_unit
   import gsa_pkg::*;
;

   localparam int QUIET_LIMIT = 4000;

   // One request beat and the response it should produce
   typedef struct packed {
      logic [2:0]          func;
      logic [ID_BITS-1:0]  slot_id;
      logic [GEN_BITS-1:0] handle_generation;
   } pool_request_type;

   typedef struct packed {
      logic                ok;
      logic [ID_BITS-1:0]  result_id;
      logic [GEN_BITS-1:0] result_generation;
      logic [ID_BITS-1:0]  live_total;
   } pool_outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_func;
   logic [ID_BITS-1:0]  req_slot_id;
   logic [GEN_BITS-1:0] req_handle_generation;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_ok;
   logic [ID_BITS-1:0]  rsp_result_id;
   logic [GEN_BITS-1:0] rsp_result_generation;
   logic [ID_BITS-1:0]  rsp_live_total;
   logic                csr_valid;
   logic                csr_ready;
   logic [LIM_BITS-1:0] csr_data;

   pool_request_type request_backlog_q[$];
   pool_outcome_type outcome_due_q[$];

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int quiet_cycles;

   // Shadow copy of the pool
   logic [LIM_BITS-1:0] pool_limit;
   int                  pool_free_head;
   int                  pool_next_fresh;
   int                  pool_live_count;
   int                  pool_link [SLOTS];
   logic [GEN_BITS-1:0] pool_gen [SLOTS];
   logic                pool_live [SLOTS];

   generational_slot_allocator_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_slot_id           (req_slot_id),
      .req_handle_generation (req_handle_generation),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_ok                (rsp_ok),
      .rsp_result_id         (rsp_result_id),
      .rsp_result_generation (rsp_result_generation),
      .rsp_live_total        (rsp_live_total),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   // Clock and known input levels from time zero
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_ALLOC;
      req_slot_id = '0;
      req_handle_generation = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      forever #2 clock = ~clock;
   end

   // Apply one operation to the shadow pool and work out its response
   task automatic pool_apply_op(input logic [2:0] func, input logic [ID_BITS-1:0] id,
                                input logic [GEN_BITS-1:0] hgen,
                                output pool_outcome_type res);
      int                  lim;
      int                  grant;
      logic                used;
      logic [GEN_BITS-1:0] g;
      lim = (pool_limit < LIMIT_MIN) ? LIMIT_MIN :
            (pool_limit > LIMIT_MAX) ? LIMIT_MAX : pool_limit;
      used = (id != 0) && (int'(id) < pool_next_fresh);
      res.ok = 1'b0;
      res.result_id = id;
      res.result_generation = '0;
      case (func)
         FUNC_ALLOC: begin
            grant = 0;
            if (pool_free_head != 0) begin
               grant = pool_free_head;
               pool_free_head = pool_link[grant];
            end else if (pool_next_fresh < lim) begin
               grant = pool_next_fresh;
               pool_next_fresh++;
               pool_gen[grant] = 1;
            end
            if (grant != 0) begin
               pool_live[grant] = 1'b1;
               pool_live_count++;
               res.ok = 1'b1;
               res.result_generation = pool_gen[grant];
            end
            res.result_id = ID_BITS'(grant);
         end
         FUNC_FREE: begin
            if (used && pool_live[id]) begin
               g = pool_gen[id] + 1'b1;
               // wrap skips the zero generation
               if (g == 0) g = 1;
               pool_gen[id] = g;
               pool_live[id] = 1'b0;
               pool_live_count--;
               pool_link[id] = pool_free_head;
               pool_free_head = id;
               res.ok = 1'b1;
            end
            res.result_generation = used ? pool_gen[id] : '0;
         end
         FUNC_VALIDATE: begin
            res.ok = used && pool_live[id] && (pool_gen[id] == hgen);
            res.result_generation = used ? pool_gen[id] : '0;
         end
         FUNC_MAKE: begin
            res.ok = 1'b1;
            res.result_generation = used ? pool_gen[id] : '0;
         end
         FUNC_IS_LIVE: begin
            res.ok = used && pool_live[id];
            res.result_generation = used ? pool_gen[id] : '0;
         end
         default: ;
      endcase
      res.live_total = ID_BITS'(pool_live_count);
   endtask

   function automatic pool_request_type make_op(input logic [2:0] func,
                                                input logic [ID_BITS-1:0] id,
                                                input logic [GEN_BITS-1:0] hgen);
      pool_request_type r;
      r.func = func;
      r.slot_id = id;
      r.handle_generation = hgen;
      return r;
   endfunction

   // Mostly well-formed traffic: ids taken from the live set, real generations
   function automatic pool_request_type make_random_op(input int live_ids[$]);
      pool_request_type r;
      int               roll;
      int               top;
      logic             pick_live;
      r.handle_generation = GEN_BITS'($urandom());
      r.slot_id = ID_BITS'($urandom());
      top = (pool_next_fresh < SLOTS) ? pool_next_fresh : SLOTS - 1;
      pick_live = (live_ids.size() != 0) && ($urandom_range(0, 9) < 8);
      if (pick_live)
         r.slot_id = ID_BITS'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
      else if ($urandom_range(0, 1) == 0)
         r.slot_id = ID_BITS'($urandom_range(0, top));
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         r.func = FUNC_ALLOC;
      end else if (roll < 55) begin
         r.func = FUNC_FREE;
      end else if (roll < 75) begin
         r.func = FUNC_VALIDATE;
         if (pick_live) begin
            r.handle_generation = pool_gen[r.slot_id];
            if ($urandom_range(0, 2) == 0)
               r.handle_generation ^= GEN_BITS'(1) << $urandom_range(0, GEN_BITS - 1);
         end
      end else if (roll < 85) begin
         r.func = FUNC_MAKE;
      end else if (roll < 95) begin
         r.func = FUNC_IS_LIVE;
      end else begin
         r.func = FUNC_IS_LIVE + 3'($urandom_range(1, 3));
      end
      return r;
   endfunction

   // Checked between edges so that beats launched at the last edge are seen
   task automatic wait_idle();
      @(negedge clock);
      while (request_backlog_q.size() != 0 || req_valid || outcome_due_q.size() != 0)
         @(negedge clock);
   endtask

   // Feed random beats in short bursts, each drawn from the current pool state
   task automatic queue_random_ops(input int total);
      int i;
      int n;
      int issued;
      int live_ids[$];
      issued = 0;
      while (issued < total) begin
         @(negedge clock);
         if (request_backlog_q.size() == 0) begin
            live_ids.delete();
            for (i = 1; i < pool_next_fresh; i++)
               if (pool_live[i]) live_ids.push_back(i);
            for (n = 0; n < 8 && issued < total; n++) begin
               request_backlog_q.push_back(make_random_op(live_ids));
               issued++;
            end
         end
      end
   endtask

   // Register write, only with the pipeline drained
   task automatic write_slot_limit(input logic [LIM_BITS-1:0] value);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pool_limit = value;
   endtask

   // Request driver: predicts each accepted beat, then offers the next one
   always @(posedge clock) begin
      pool_request_type nxt;
      pool_outcome_type due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pool_apply_op(req_func, req_slot_id, req_handle_generation, due);
            outcome_due_q.push_back(due);
         end
         if (!req_valid || !req_stall) begin
            if (request_backlog_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = request_backlog_q.pop_front();
               req_valid <= 1'b1;
               req_func <= nxt.func;
               req_slot_id <= nxt.slot_id;
               req_handle_generation <= nxt.handle_generation;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each accepted beat with the oldest prediction
   always @(posedge clock) begin
      pool_outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_due_q.size() == 0) begin
               $error("unexpected response beat: result_id %0d", rsp_result_id);
               fail_count++;
            end else begin
               want = outcome_due_q.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("ok: expected %0d, actual %0d", want.ok, rsp_ok);
                  fail_count++;
               end
               if (rsp_result_id !== want.result_id) begin
                  $error("result_id: expected %0d, actual %0d", want.result_id, rsp_result_id);
                  fail_count++;
               end
               if (rsp_result_generation !== want.result_generation) begin
                  $error("result_generation: expected %0d, actual %0d",
                         want.result_generation, rsp_result_generation);
                  fail_count++;
               end
               if (rsp_live_total !== want.live_total) begin
                  $error("live_total: expected %0d, actual %0d",
                         want.live_total, rsp_live_total);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus sequence
   initial begin
      int i;
      fail_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 32;
      recv_idle_pct = 52;
      pool_limit = LIMIT_RESET;
      pool_free_head = 0;
      pool_next_fresh = 1;
      pool_live_count = 0;
      for (i = 0; i < SLOTS; i++) begin
         pool_link[i] = 0;
         pool_gen[i] = '0;
         pool_live[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: bump alloc, null id, double free, out-of-range ids, reuse, spare codes
      @(negedge clock);
      request_backlog_q.push_back(make_op(FUNC_ALLOC, '0, '0));
      request_backlog_q.push_back(make_op(FUNC_ALLOC, '1, '1));
      request_backlog_q.push_back(make_op(FUNC_MAKE, '0, '0));
      request_backlog_q.push_back(make_op(FUNC_VALIDATE, 10'd1, 16'd1));
      request_backlog_q.push_back(make_op(FUNC_VALIDATE, 10'd1, '1));
      request_backlog_q.push_back(make_op(FUNC_IS_LIVE, 10'd2, '0));
      request_backlog_q.push_back(make_op(FUNC_FREE, 10'd1, '0));
      request_backlog_q.push_back(make_op(FUNC_FREE, 10'd1, '0));
      request_backlog_q.push_back(make_op(FUNC_VALIDATE, 10'd1, 16'd2));
      request_backlog_q.push_back(make_op(FUNC_IS_LIVE, 10'd1, '0));
      request_backlog_q.push_back(make_op(FUNC_FREE, '0, '0));
      request_backlog_q.push_back(make_op(FUNC_FREE, '1, '0));
      request_backlog_q.push_back(make_op(FUNC_VALIDATE, '1, '0));
      request_backlog_q.push_back(make_op(FUNC_MAKE, '1, '1));
      request_backlog_q.push_back(make_op(FUNC_MAKE, 10'd1, '0));
      request_backlog_q.push_back(make_op(FUNC_ALLOC, '0, '0));
      request_backlog_q.push_back(make_op(FUNC_ALLOC, '0, '0));
      request_backlog_q.push_back(make_op(FUNC_IS_LIVE + 3'd1, '1, '1));
      request_backlog_q.push_back(make_op(FUNC_IS_LIVE + 3'd2, '0, '0));
      request_backlog_q.push_back(make_op(FUNC_IS_LIVE + 3'd3, 10'd512, '0));
      request_backlog_q.push_back(make_op(FUNC_IS_LIVE, 10'd3, '0));
      request_backlog_q.push_back(make_op(FUNC_FREE, 10'd4, '0));

      // Sender idles less than the receiver
      queue_random_ops(110);
      write_slot_limit('0);
      queue_random_ops(100);

      // Receiver idles less than the sender
      send_idle_pct = 52;
      recv_idle_pct = 32;
      write_slot_limit('1);
      queue_random_ops(110);
      write_slot_limit(LIM_BITS'(300));
      queue_random_ops(110);

      // No idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_slot_limit(LIMIT_MIN);
      queue_random_ops(110);
      write_slot_limit(LIMIT_MAX + 1'b1);
      queue_random_ops(110);

      wait_idle();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/gsa_pkg.sv
rtl/core/gsa_slot_mem.sv
rtl/core/generational_slot_allocator_unit.sv
tb/tb_generational_slot_allocator_unit.sv
